FILE: src/rac_pkg.sv
// Shared types and constants for the ROC AUC engine.
package rac_pkg;

    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int SCORE_BITS_DEF = 16;
    localparam int AUC_FRAC       = 16;            // fraction bits of auc
    localparam int AUC_W          = AUC_FRAC + 1;  // auc field width
    localparam logic [AUC_W-1:0] AUC_ONE = AUC_W'(1) << AUC_FRAC;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_OUTER_RD,
        ST_OUTER_LAT,
        ST_INNER,
        ST_NEXT_I,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } rac_state_t;

endpackage

FILE: src/roc_auc_engine.sv
// Top level of the ROC AUC engine: sample store, pair walk sequencer, result.
//
//  channel | dir | beat contents
//  s_      | in  | tdata: label[0], score[SCORE_BITS:1]; tlast ends the set
//  m_      | out | tdata: auc[16:0], sample_count above; tuser: degenerate, overflowed
//
// Load: one sample per cycle into the sample RAM; samples beyond MAX_ITEMS are dropped and flagged.
// After the last sample s_tready stays low while the set is evaluated: the
// single RAM read port walks every sample for each positive, then one multiply
// and a 17-step divider produce auc.
// A set with no positives or no negatives skips the walk.
// Reset clears counts and control; the RAM keeps its contents.
// s_tready is low during evaluation; a result waits in the output register.
module roc_auc_engine
    import rac_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((SCORE_BITS+8)/8)*8-1:0] s_tdata,   // label, score
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((AUC_W+$clog2(MAX_ITEMS+1)+7)/8)*8-1:0] m_tdata, // auc, sample_count
    output logic [1:0] m_tuser                          // degenerate, overflowed
);

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int ACCW = 2 * CW + 1;
    localparam int NW   = ACCW + AUC_FRAC + 1;
    localparam int OW   = ((AUC_W + CW + 7) / 8) * 8;
    localparam int RW   = SCORE_BITS + 1;

    rac_state_t state_reg, state_next;

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         neg_reg, neg_next;
    logic [AW-1:0]         i_reg, i_next;
    logic [AW-1:0]         j_reg, j_next;
    logic [SCORE_BITS-1:0] pscore_reg, pscore_next;
    logic [ACCW-1:0]       acc_reg, acc_next;
    logic                  cmp_vld_reg;
    logic [2*CW-1:0]       pn_reg, pn_next;
    logic                  m_valid_reg, m_valid_next;
    logic [AUC_W-1:0]      auc_reg, auc_next;
    logic                  degen_reg, degen_next;
    logic                  movf_reg, movf_next;
    logic [CW-1:0]         mcnt_reg, mcnt_next;

    logic                  s_acc;
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [RW-1:0]         ram_rdata;
    logic [AW-1:0]         last_idx;
    logic                  div_start;
    logic                  div_done;
    logic [AUC_W-1:0]      div_q;
    logic [NW-1:0]         div_num;
    logic [NW-1:0]         div_den;

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign ram_we    = s_acc && (cnt_reg != CW'(MAX_ITEMS));
    assign last_idx  = AW'(cnt_reg - CW'(1));
    assign ram_raddr = (state_reg == ST_INNER) ? j_reg : i_reg;

    rac_ram #(.W(RW), .DEPTH(MAX_ITEMS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(cnt_reg)),
        .wdata ({s_tdata[0], s_tdata[SCORE_BITS:1]}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_num = (NW'(acc_reg) << AUC_FRAC) + NW'(pn_reg);
    assign div_den = NW'({pn_reg, 1'b0});

    rac_div #(.NW(NW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    // sequencer and datapath
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pscore_next  = pscore_reg;
        acc_next     = acc_reg;
        pn_next      = pn_reg;
        m_valid_next = m_valid_reg;
        auc_next     = auc_reg;
        degen_next   = degen_reg;
        movf_next    = movf_reg;
        mcnt_next    = mcnt_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // pair compare on data read in the previous cycle
        if (cmp_vld_reg && !ram_rdata[RW-1]) begin
            if (pscore_reg > ram_rdata[SCORE_BITS-1:0]) begin
                acc_next = acc_reg + ACCW'(2);
            end else if (pscore_reg == ram_rdata[SCORE_BITS-1:0]) begin
                acc_next = acc_reg + ACCW'(1);
            end
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (ram_we) begin
                        cnt_next = cnt_reg + CW'(1);
                        if (s_tdata[0]) begin
                            pos_next = pos_reg + CW'(1);
                        end else begin
                            neg_next = neg_reg + CW'(1);
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                i_next   = '0;
                acc_next = '0;
                if (pos_reg == '0 || neg_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_OUTER_RD;
                end
            end
            ST_OUTER_RD: begin
                state_next = ST_OUTER_LAT;
            end
            ST_OUTER_LAT: begin
                if (ram_rdata[RW-1]) begin
                    pscore_next = ram_rdata[SCORE_BITS-1:0];
                    j_next      = '0;
                    state_next  = ST_INNER;
                end else if (i_reg == last_idx) begin
                    state_next = ST_MUL;
                end else begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_OUTER_RD;
                end
            end
            ST_INNER: begin
                j_next = j_reg + AW'(1);
                if (j_reg == last_idx) begin
                    state_next = ST_NEXT_I;
                end
            end
            ST_NEXT_I: begin
                if (i_reg == last_idx) begin
                    state_next = ST_MUL;
                end else begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_OUTER_RD;
                end
            end
            ST_MUL: begin
                pn_next    = (2*CW)'(pos_reg) * (2*CW)'(neg_reg);
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    degen_next   = (pos_reg == '0) || (neg_reg == '0);
                    if (degen_next) begin
                        auc_next = '0;
                    end else if (div_q > AUC_ONE) begin
                        auc_next = AUC_ONE;
                    end else begin
                        auc_next = div_q;
                    end
                    movf_next  = ovf_reg;
                    mcnt_next  = cnt_reg;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    pos_next   = '0;
                    neg_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            pos_reg     <= '0;
            neg_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            pos_reg     <= pos_next;
            neg_reg     <= neg_next;
            cmp_vld_reg <= (state_reg == ST_INNER);
            m_valid_reg <= m_valid_next;
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        pscore_reg <= pscore_next;
        acc_reg    <= acc_next;
        pn_reg     <= pn_next;
        auc_reg    <= auc_next;
        degen_reg  <= degen_next;
        movf_reg   <= movf_next;
        mcnt_reg   <= mcnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OW'({mcnt_reg, auc_reg});
    assign m_tuser  = {movf_reg, degen_reg};

endmodule

FILE: src/rac_ram.sv
// Generic simple dual-port RAM with registered read.
module rac_ram
    import rac_pkg::*;
#(
    parameter int W     = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rac_div.sv
// Restoring divider, one quotient bit per cycle.
module rac_div
    import rac_pkg::*;
#(
    parameter int NW = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NW-1:0]    num,
    input  logic [NW-1:0]    den,
    output logic             done,
    output logic [AUC_W-1:0] quot
);

    localparam int KW = $clog2(AUC_W + 1);

    logic [NW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    dsh_reg, dsh_next;
    logic [AUC_W-1:0] q_reg, q_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             ge;

    // one compare and subtract per cycle
    always_comb begin
        ge        = rem_reg >= dsh_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            dsh_next  = den << (AUC_W - 1);
            q_next    = '0;
            k_next    = KW'(AUC_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[AUC_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            k_next   = k_reg - KW'(1);
            if (k_reg == KW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: src/rac_chk.sv
// Port-level checker for the ROC AUC engine, bound to the top level.
module rac_chk
    import rac_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((SCORE_BITS+8)/8)*8-1:0] s_tdata,
    input logic s_tlast,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((AUC_W+$clog2(MAX_ITEMS+1)+7)/8)*8-1:0] m_tdata,
    input logic [1:0] m_tuser
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    // result holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // degenerate set reports zero auc
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[AUC_W-1:0] == '0)
        else $error("degenerate result with nonzero auc");

    // auc never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[AUC_W-1:0] <= AUC_ONE)
        else $error("auc above one");

    // stored count never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[AUC_W+CW-1:AUC_W] <= CW'(MAX_ITEMS))
        else $error("sample count above capacity");

    // the last sample of a set closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after last sample");

endmodule

bind roc_auc_engine rac_chk #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SCORE_BITS (SCORE_BITS)
) u_rac_chk (.*);

FILE: bench/tb_roc_auc_engine.sv
// Testbench for roc_auc_engine: directed and random sample sets checked against a local AUC model.
module tb_roc_auc_engine;
    import rac_pkg::*;

    localparam int CAP       = MAX_ITEMS_DEF;
    localparam int SW        = SCORE_BITS_DEF;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int S_W       = ((SW + 8) / 8) * 8;
    localparam int M_W       = ((AUC_W + CNT_W + 7) / 8) * 8;
    localparam int STALL_MAX = 50000;

    typedef struct packed {
        logic [AUC_W-1:0] auc;
        logic             degenerate;
        logic             overflowed;
        logic [CNT_W-1:0] sample_count;
    } auc_result_t;

    typedef struct packed {
        logic          label;
        logic [SW-1:0] score;
    } sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;   // label, score
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;        // auc, sample_count
    logic [1:0] m_tuser;            // degenerate, overflowed

    // sender gap and receiver stall rates, percent
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    // samples of the open set as seen by the model, and pending results
    sample_t     set_samples[$];
    logic        set_dropped;
    auc_result_t auc_expected[$];

    roc_auc_engine u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // AUC over the stored set: positive above negative counts 2, tie counts 1
    function automatic auc_result_t evaluate_set(sample_t smp[$], logic dropped);
        auc_result_t r;
        longint unsigned pos, neg, acc, pn, a;
        pos = 0;
        neg = 0;
        acc = 0;
        a = 0;
        foreach (smp[i]) begin
            if (!smp[i].label) begin
                neg++;
            end else begin
                pos++;
                foreach (smp[j]) begin
                    if (!smp[j].label) begin
                        if (smp[i].score > smp[j].score) acc += 2;
                        else if (smp[i].score == smp[j].score) acc += 1;
                    end
                end
            end
        end
        r.degenerate = (pos == 0) || (neg == 0);
        if (!r.degenerate) begin
            pn = pos * neg;
            a = (acc * 65536 + pn) / (2 * pn);
            if (a > 65536) a = 65536;
        end
        r.auc = AUC_W'(a);
        r.overflowed = dropped;
        r.sample_count = CNT_W'(smp.size());
        return r;
    endfunction

    // input beats feed the model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            if (set_samples.size() < CAP)
                set_samples.insert(set_samples.size(), {s_tdata[0], s_tdata[SW:1]});
            else set_dropped = 1'b1;
            if (s_tlast) begin
                auc_expected.insert(auc_expected.size(),
                                    evaluate_set(set_samples, set_dropped));
                set_samples.delete();
                set_dropped = 1'b0;
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        auc_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.auc = m_tdata[AUC_W-1:0];
            got.sample_count = m_tdata[AUC_W +: CNT_W];
            got.degenerate = m_tuser[0];
            got.overflowed = m_tuser[1];
            if (auc_expected.size() == 0) begin
                $display("%0t: unexpected result auc=%0d deg=%0b ovf=%0b cnt=%0d", $time,
                         got.auc, got.degenerate, got.overflowed, got.sample_count);
                errors++;
            end else begin
                want = auc_expected.pop_front();
                if (got.auc !== want.auc) begin
                    $display("%0t: auc expected %0d actual %0d", $time, want.auc, got.auc);
                    errors++;
                end
                if (got.degenerate !== want.degenerate) begin
                    $display("%0t: degenerate expected %0b actual %0b", $time,
                             want.degenerate, got.degenerate);
                    errors++;
                end
                if (got.overflowed !== want.overflowed) begin
                    $display("%0t: overflowed expected %0b actual %0b", $time,
                             want.overflowed, got.overflowed);
                    errors++;
                end
                if (got.sample_count !== want.sample_count) begin
                    $display("%0t: sample_count expected %0d actual %0d", $time,
                             want.sample_count, got.sample_count);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one sample beat, with an optional random gap before it
    task automatic send_sample(input logic label, input logic [SW-1:0] score,
                               input logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({score, label});
        s_tlast  <= last;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // step past the last beat's edge so its result is queued, then wait until all are checked
    task automatic wait_drained();
        @(posedge aclk);
        while (auc_expected.size() != 0) @(posedge aclk);
    endtask

    // extremes, ties, separation and single-class sets
    task automatic test_directed();
        // all tied at top score: 0.5
        send_sample(1'b1, '1, 1'b0);
        send_sample(1'b0, '1, 1'b0);
        send_sample(1'b1, '1, 1'b0);
        send_sample(1'b0, '1, 1'b1);
        // perfect separation: 1.0
        send_sample(1'b0, '0, 1'b0);
        send_sample(1'b1, '1, 1'b0);
        send_sample(1'b0, 16'h0001, 1'b0);
        send_sample(1'b1, 16'h8000, 1'b1);
        // inverted: 0.0
        send_sample(1'b1, '0, 1'b0);
        send_sample(1'b0, '1, 1'b1);
        // single sample, positives only, negatives only
        send_sample(1'b1, 16'h5555, 1'b1);
        send_sample(1'b0, 16'hAAAA, 1'b1);
        send_sample(1'b1, 16'h1234, 1'b0);
        send_sample(1'b1, 16'h4321, 1'b1);
        send_sample(1'b0, 16'h7FFF, 1'b0);
        send_sample(1'b0, 16'h0000, 1'b1);
        // thirds with a partial tie
        send_sample(1'b1, 16'h0100, 1'b0);
        send_sample(1'b0, 16'h0100, 1'b0);
        send_sample(1'b0, 16'h0200, 1'b0);
        send_sample(1'b0, 16'h0050, 1'b1);
        go_idle();
        wait_drained();
    endtask

    // fill the store exactly, then drop samples; last beat itself is dropped
    task automatic test_capacity();
        for (int k = 0; k < CAP + 3; k++) begin
            send_sample((k % 400) == 7, SW'($urandom), k == CAP + 2);
        end
        go_idle();
        wait_drained();
    endtask

    // random sets, mostly small, some with narrow score ranges to force ties
    task automatic test_random(input int sender_pct, input int receiver_pct,
                               input int n_items);
        int sent;
        int len;
        int span;
        int pos_pct;
        send_idle_pct = sender_pct;
        recv_stall_pct = receiver_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
            span = ($urandom_range(2) == 0) ? 3 : 65535;
            pos_pct = $urandom_range(100);
            for (int k = 0; k < len; k++) begin
                send_sample($urandom_range(99) < pos_pct, SW'($urandom_range(span)),
                            k == len - 1);
            end
            sent += len;
        end
        go_idle();
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        set_dropped = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity();
        test_random(0, 0, 150);
        test_random(70, 0, 150);
        test_random(0, 70, 150);
        test_random(26, 26, 150);
        repeat (200) @(posedge aclk);
        if (errors == 0 && auc_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
